### rtl/lhs_pkg.sv
package lhs_pkg;

   localparam int unsigned PIX_W = 8;
   localparam int unsigned NUM_W = 2 * PIX_W;
   localparam int unsigned CNT_W = $clog2(PIX_W);

   localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
   localparam logic [PIX_W-1:0] MIN_RESET  = 8'd255;
   localparam logic [PIX_W-1:0] MAX_RESET  = 8'd0;

   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_STRETCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

### rtl/linear_histogram_stretch.sv
// Linear contrast stretch of 8-bit pixels from a measured minimum and maximum.
// The input channel (req_) carries transactions of two kinds. A measure
// transaction (req_op = 0) folds req_pixel into the frame minimum and maximum;
// req_first = 1 restarts both from that pixel. It gives no result and does not
// hold the input. A stretch transaction (req_op = 1) gives one result on the rsp_
// channel: floor((p - min) * 255 / (max - min)), clamped to 0..255, or the
// pixel unchanged with rsp_flat_range = 1 when max is not above min.
// Send the frame once to measure and once more to stretch.
// A stretch runs through a restoring divider that yields one quotient bit per
// cycle, the last only once the output register is free; a divided pixel holds
// req_stall until its result loads into the output register. Flat, at-or-below-min
// and at-or-above-max pixels skip the divider and wait in ST_DONE for that register.
// A finished result waits in the output register while rsp_stall is high; a
// following stretch then holds req_stall at its last divider step or in ST_DONE.
// Reset sets the minimum to 255 and the maximum to 0 (a flat range) and
// empties the output register.
module linear_histogram_stretch
   import lhs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_op,
   input  logic [PIX_W-1:0] req_pixel,
   input  logic             req_first,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PIX_W-1:0] rsp_out_pixel,
   output logic             rsp_flat_range
);

   state_type        state_ff, state_in;
   logic [PIX_W-1:0] min_ff, min_in;
   logic [PIX_W-1:0] max_ff, max_in;
   logic [PIX_W-1:0] rem_ff, rem_in;
   logic [PIX_W-1:0] num_lo_ff, num_lo_in;
   logic [PIX_W-1:0] quo_ff, quo_in;
   logic [PIX_W-1:0] range_ff, range_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             flat_ff, flat_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic             rsp_flat_ff, rsp_flat_in;

   logic             accept;
   logic             out_free;
   logic             range_flat;
   logic [PIX_W-1:0] diff;
   logic [NUM_W-1:0] num;
   logic [PIX_W:0]   trial;
   logic             ge;
   logic [PIX_W-1:0] quo_next;
   logic             last_step;

   assign req_stall      = (state_ff != ST_IDLE);
   assign accept         = req_valid && !req_stall;
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign range_flat     = (max_ff <= min_ff);
   assign diff           = req_pixel - min_ff;
   assign num            = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};
   assign trial          = {rem_ff, num_lo_ff[PIX_W-1]};
   assign ge             = (trial >= {1'b0, range_ff});
   assign quo_next       = {quo_ff[PIX_W-2:0], ge};
   assign last_step      = (cnt_ff == CNT_W'(PIX_W - 1));
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_pixel  = rsp_pixel_ff;
   assign rsp_flat_range = rsp_flat_ff;

   always_comb begin
      state_in     = state_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rem_in       = rem_ff;
      num_lo_in    = num_lo_ff;
      quo_in       = quo_ff;
      range_in     = range_ff;
      cnt_in       = cnt_ff;
      flat_in      = flat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_flat_in  = rsp_flat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_MEASURE) begin
               if (req_first) begin
                  min_in = req_pixel;
                  max_in = req_pixel;
               end else begin
                  if (req_pixel < min_ff) min_in = req_pixel;
                  if (req_pixel > max_ff) max_in = req_pixel;
               end
            end else if (accept) begin
               flat_in = range_flat;
               state_in = ST_DONE;
               if (range_flat) begin
                  quo_in = req_pixel;
               end else if (req_pixel <= min_ff) begin
                  quo_in = '0;
               end else if (req_pixel >= max_ff) begin
                  quo_in = FULL_SCALE;
               end else begin
                  rem_in    = num[NUM_W-1:PIX_W];
                  num_lo_in = num[PIX_W-1:0];
                  range_in  = max_ff - min_ff;
                  quo_in    = '0;
                  cnt_in    = '0;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (last_step) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_pixel_in = quo_next;
                  rsp_flat_in  = flat_ff;
                  state_in     = ST_IDLE;
               end
            end else begin
               rem_in    = ge ? trial[PIX_W-1:0] - range_ff : trial[PIX_W-1:0];
               num_lo_in = {num_lo_ff[PIX_W-2:0], 1'b0};
               quo_in    = quo_next;
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = quo_ff;
               rsp_flat_in  = flat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= MIN_RESET;
         max_ff       <= MAX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      num_lo_ff    <= num_lo_in;
      quo_ff       <= quo_in;
      range_ff     <= range_in;
      cnt_ff       <= cnt_in;
      flat_ff      <= flat_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_flat_ff  <= rsp_flat_in;
   end

endmodule

### rtl/lhs_checker.sv
module lhs_checker
   import lhs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic             req_op,
   input  logic [PIX_W-1:0] req_pixel,
   input  logic             req_first,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [PIX_W-1:0] rsp_out_pixel,
   input  logic             rsp_flat_range
);

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_pixel)
         && $stable(rsp_flat_range))
      else $error("stalled result transaction changed");

   // an accepted stretch then holds the input with req_stall
   a_stretch_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == OP_STRETCH |=> req_stall)
      else $error("stretch transaction did not hold the input");

   // measure leaves the input free in the cycle after acceptance
   a_measure_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == OP_MEASURE |=> !req_stall)
      else $error("measure transaction held the input");

   // results only come out of a stretch in progress
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result transaction without stretch in progress");

   // release the input in the cycle the result appears on rsp_valid
   a_done_release: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("input not released after result load");

endmodule

bind linear_histogram_stretch lhs_checker u_lhs_checker (.*);

### dv/linear_histogram_stretch_tb.sv
module linear_histogram_stretch_tb;
   import lhs_pkg::*;

   localparam int unsigned ITEM_TARGET  = 1700;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned LONG_HOLD    = 200;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned HOLD_FRAME   = 12;
   localparam int unsigned PAUSE_EVERY  = 8;

   typedef struct packed {
      logic [PIX_W-1:0] out_pixel;
      logic             flat_range;
   } stretched_type;

   typedef struct packed {
      logic             op;
      logic [PIX_W-1:0] pixel;
      logic             first;
      logic             typed;
      logic [PIX_W-1:0] out_pixel;
      logic             flat_range;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [25] = '{
      '{OP_STRETCH, 8'd0,   1'b0, 1'b1, 8'd0,   1'b1},
      '{OP_STRETCH, 8'd255, 1'b0, 1'b1, 8'd255, 1'b1},
      '{OP_STRETCH, 8'hA5,  1'b1, 1'b1, 8'hA5,  1'b1},
      '{OP_MEASURE, 8'd100, 1'b1, 1'b0, 8'd0,   1'b0},
      '{OP_STRETCH, 8'd100, 1'b0, 1'b1, 8'd100, 1'b1},
      '{OP_MEASURE, 8'd200, 1'b0, 1'b0, 8'd0,   1'b0},
      '{OP_STRETCH, 8'd50,  1'b0, 1'b1, 8'd0,   1'b0},
      '{OP_STRETCH, 8'd100, 1'b0, 1'b1, 8'd0,   1'b0},
      '{OP_STRETCH, 8'd250, 1'b1, 1'b1, 8'd255, 1'b0},
      '{OP_STRETCH, 8'd200, 1'b0, 1'b1, 8'd255, 1'b0},
      '{OP_STRETCH, 8'd150, 1'b0, 1'b0, 8'd0,   1'b0},
      '{OP_STRETCH, 8'd170, 1'b1, 1'b0, 8'd0,   1'b0},
      '{OP_MEASURE, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
      '{OP_MEASURE, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
      '{OP_STRETCH, 8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
      '{OP_STRETCH, 8'd255, 1'b0, 1'b1, 8'd255, 1'b0},
      '{OP_STRETCH, 8'd128, 1'b0, 1'b0, 8'd0,   1'b0},
      '{OP_STRETCH, 8'd1,   1'b1, 1'b0, 8'd0,   1'b0},
      '{OP_MEASURE, 8'd7,   1'b1, 1'b0, 8'd0,   1'b0},
      '{OP_MEASURE, 8'd8,   1'b0, 1'b0, 8'd0,   1'b0},
      '{OP_STRETCH, 8'd7,   1'b0, 1'b1, 8'd0,   1'b0},
      '{OP_STRETCH, 8'd8,   1'b0, 1'b1, 8'd255, 1'b0},
      '{OP_STRETCH, 8'd9,   1'b0, 1'b1, 8'd255, 1'b0},
      '{OP_MEASURE, 8'd85,  1'b1, 1'b0, 8'd0,   1'b0},
      '{OP_STRETCH, 8'd85,  1'b0, 1'b1, 8'd85,  1'b1}
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic             req_op;
   logic [PIX_W-1:0] req_pixel;
   logic             req_first;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [PIX_W-1:0] rsp_out_pixel;
   logic             rsp_flat_range;

   logic             row_typed;
   logic [PIX_W-1:0] row_out_pixel;
   logic             row_flat_range;

   logic [PIX_W-1:0] frame_lo;
   logic [PIX_W-1:0] frame_hi;
   stretched_type    stretched_q [$];

   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;
   int unsigned sent_count     = 0;
   bit          no_gaps        = 1'b0;
   int unsigned hold_requests  = 0;

   linear_histogram_stretch i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_pixel      (req_pixel),
      .req_first      (req_first),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_pixel  (rsp_out_pixel),
      .rsp_flat_range (rsp_flat_range)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic stretched_type stretch_predict(logic [PIX_W-1:0] pixel,
                                                     logic [PIX_W-1:0] lo,
                                                     logic [PIX_W-1:0] hi);
      stretched_type res;
      int unsigned   pv;
      int unsigned   lov;
      int unsigned   hiv;
      int unsigned   quot;
      pv  = 32'(pixel);
      lov = 32'(lo);
      hiv = 32'(hi);
      if (hiv <= lov) begin
         res.out_pixel  = pixel;
         res.flat_range = 1'b1;
      end else begin
         if (pv <= lov) begin
            quot = 0;
         end else begin
            quot = ((pv - lov) * 32'(FULL_SCALE)) / (hiv - lov);
            if (quot > 32'(FULL_SCALE)) begin
               quot = 32'(FULL_SCALE);
            end
         end
         res.out_pixel  = quot[PIX_W-1:0];
         res.flat_range = 1'b0;
      end
      return res;
   endfunction

   // check the result first, then fold in the transaction accepted at this edge
   always @(posedge clock) begin
      stretched_type predicted;
      stretched_type oldest;
      if (reset) begin
         frame_lo = MIN_RESET;
         frame_hi = MAX_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (stretched_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, %s %0d %s %0b",
                        $time, "actual out_pixel", rsp_out_pixel, "flat_range",
                        rsp_flat_range);
               error_count++;
            end else begin
               oldest = stretched_q.pop_front();
               if (rsp_out_pixel !== oldest.out_pixel) begin
                  $display("%0t: out_pixel mismatch: expected %0d actual %0d",
                           $time, oldest.out_pixel, rsp_out_pixel);
                  error_count++;
               end
               if (rsp_flat_range !== oldest.flat_range) begin
                  $display("%0t: flat_range mismatch: expected %0b actual %0b",
                           $time, oldest.flat_range, rsp_flat_range);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_op == OP_MEASURE) begin
               if (req_first) begin
                  frame_lo = req_pixel;
                  frame_hi = req_pixel;
               end else begin
                  if (req_pixel < frame_lo) frame_lo = req_pixel;
                  if (req_pixel > frame_hi) frame_hi = req_pixel;
               end
            end else begin
               predicted = stretch_predict(req_pixel, frame_lo, frame_hi);
               if (row_typed) begin
                  predicted.out_pixel  = row_out_pixel;
                  predicted.flat_range = row_flat_range;
               end
               stretched_q.push_back(predicted);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int unsigned hold_left;
      int unsigned holds_served;
      int unsigned pick;
      hold_left    = 0;
      holds_served = 0;
      rsp_stall    = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
         end
         if (hold_left != 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = 1'b0;
            if (!no_gaps) begin
               pick = $urandom_range(0, 99);
               if (pick < 55)      hold_left = 0;
               else if (pick < 85) hold_left = $urandom_range(1, 2);
               else if (pick < 97) hold_left = $urandom_range(3, 10);
               else                hold_left = $urandom_range(15, 50);
            end
         end
      end
   end

   // enter and leave at a falling edge; valid stays high for a following transaction
   task automatic send_item(input logic op, input logic [PIX_W-1:0] pixel,
                            input logic first, input logic typed,
                            input logic [PIX_W-1:0] exp_pixel, input logic exp_flat);
      int unsigned pick;
      int unsigned gap;
      gap = 0;
      if (!no_gaps) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)      gap = 0;
         else if (pick < 85) gap = $urandom_range(1, 2);
         else if (pick < 97) gap = $urandom_range(3, 8);
         else                gap = $urandom_range(15, 40);
      end
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op         = op;
      req_pixel      = pixel;
      req_first      = first;
      row_typed      = typed;
      row_out_pixel  = exp_pixel;
      row_flat_range = exp_flat;
      req_valid      = 1'b1;
      do @(posedge clock); while (req_stall);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid = 1'b0;
      wait (stretched_q.size() == 0);
      @(negedge clock);
   endtask

   initial begin
      int unsigned      frame_idx;
      int unsigned      base;
      int unsigned      span;
      int unsigned      top;
      int unsigned      len;
      int unsigned      count;
      logic [PIX_W-1:0] pixel;
      logic [PIX_W-1:0] frame_px [$];
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_MEASURE;
      req_pixel      = '0;
      req_first      = 1'b0;
      row_typed      = 1'b0;
      row_out_pixel  = '0;
      row_flat_range = 1'b0;
      frame_idx      = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].first,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].out_pixel,
                   DIRECTED_ROWS[i].flat_range);
      end
      wait_for_results();

      while (sent_count < ITEM_TARGET) begin
         frame_idx++;
         if (frame_idx % PAUSE_EVERY == 0) begin
            wait_for_results();
         end
         if (frame_idx == HOLD_FRAME) begin
            hold_requests++;
         end
         no_gaps = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) begin
            count = $urandom_range(1, 8);
            repeat (count) begin
               send_item(1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 1'b0, '0, 1'b0);
            end
         end else begin
            base = $urandom_range(0, 255);
            case ($urandom_range(0, 3))
               0: begin
                  span = 0;
               end
               1: begin
                  span = $urandom_range(1, 3);
               end
               2: begin
                  span = $urandom_range(4, 60);
               end
               default: begin
                  span = $urandom_range(61, 255);
               end
            endcase
            top = (base + span > 255) ? 255 : base + span;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            frame_px.delete();
            repeat (len) frame_px.push_back(PIX_W'($urandom_range(base, top)));
            // an occasional frame without its opening restart: min and max carry over
            foreach (frame_px[i]) begin
               send_item(OP_MEASURE, frame_px[i],
                         (i == 0) && ($urandom_range(0, 19) != 0), 1'b0, '0, 1'b0);
            end
            foreach (frame_px[i]) begin
               pixel = ($urandom_range(0, 6) == 0) ? PIX_W'($urandom_range(0, 255))
                                                   : frame_px[i];
               send_item(OP_STRETCH, pixel, 1'($urandom_range(0, 1)), 1'b0, '0, 1'b0);
            end
         end
      end

      no_gaps = 1'b0;
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/lhs_pkg.sv
rtl/linear_histogram_stretch.sv
rtl/lhs_checker.sv
dv/linear_histogram_stretch_tb.sv
